@@ rtl/core/bps_pkg.sv @@
// Shared types and constants for the BPS patch applier.
// No dependencies; used by the parser and the top level.
`default_nettype none
package bps_pkg;
  // Address width of both byte stores, fixed by the 16-bit address and position ports.
  localparam int AddrBits = 16;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StMagic    = 3'd1;
  localparam logic [2:0] StSize     = 3'd2;
  localparam logic [2:0] StRange    = 3'd3;
  localparam logic [2:0] StRefused  = 3'd4;

  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpPatch = 2'd1;
  localparam logic [1:0] OpStep  = 2'd2;

  localparam logic [1:0] KindSrcRead = 2'd0;
  localparam logic [1:0] KindTgtRead = 2'd1;
  localparam logic [1:0] KindSrcCopy = 2'd2;
  localparam logic [1:0] KindTgtCopy = 2'd3;

  localparam logic [23:0] Max24 = 24'hFFFFFF;
  localparam logic [23:0] FooterLen = 24'd12;
  localparam logic [6:0] ShiftStop = 7'd64;

  typedef enum logic [3:0] {
    PhMagic0, PhMagic1, PhMagic2, PhMagic3, PhSrcSize, PhTgtSize, PhMetaSize,
    PhMetaSkip, PhCommand, PhTgtData, PhOffset, PhCopy, PhDone, PhError
  } phase_e;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h42;
      2'd1: r = 8'h50;
      2'd2: r = 8'h53;
      default: r = 8'h31;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/bps_mem.sv @@
// Byte store with one write port and one registered read port.
// No dependencies; instantiated twice by the top level.
`default_nettype none
module bps_mem #(
  parameter int AW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [7:0]         rdata_o
);
  logic [7:0] mem_q [2**AW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/core/bps_patch_apply.sv @@
// Top level of the BPS patch applier: parser, sequencer and the two byte stores.
// Depends on bps_pkg and bps_mem.
//
// Usage: write source_length (index 0) and patch_length (index 1) on the
// configuration channel, load the source with opcode 0 items, then feed the
// patch one byte per opcode 1 item and draw each pending copy byte with an
// opcode 2 item. start is taken when busy is low.
// Load items and patch bytes finish as they are taken (target-read bytes write
// the target store then). A copy step first does the synchronous store read,
// then writes the target store and presents the word; busy stays high for the
// write, so no new item is taken until a copy step is through.
// At most one result word appears, strobed by valid_o for one cycle, in the
// cycle after the item finishes work; the receiver cannot stall it.
// Reset clears the parser to expect the magic; the stores are not cleared
// and need no clearing pass.
`default_nettype none
module bps_patch_apply (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  data_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  output logic             valid_o,
  output logic [2:0]       status_o,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      out_position_o,
  output logic             last_o
);
  localparam int ADDR_BITS = bps_pkg::AddrBits;
  localparam int PW = ADDR_BITS + 2;
  localparam logic [PW-1:0] Depth = PW'(1) << ADDR_BITS;

  logic [16:0] src_len_q;
  logic [23:0] patch_len_q;
  bps_pkg::phase_e ph_q, ph_d;
  logic [63:0] acc_q, acc_d;
  logic [6:0]  sh_q, sh_d;
  logic [23:0] ppos_q, ppos_d, meta_q, meta_d, crem_q, crem_d;
  logic [PW-1:0] tpos_q, tpos_d, tsize_q, tsize_d, srel_q, srel_d, trel_q, trel_d;
  logic [1:0]  kind_q, kind_d;
  logic        rd_q;
  logic        v_d;
  logic [2:0]  st_d;
  logic [7:0]  b_d;
  logic [15:0] pos_d;
  logic        last_d;
  logic        twe;
  logic [ADDR_BITS-1:0] twaddr, sraddr, traddr;
  logic [7:0]  twdata, sdata, tdata;
  logic        swe;

  assign cfg_ready_o = 1'b1;
  assign busy = rd_q;
  wire acc_in = start && !busy;
  assign swe = acc_in && opcode_i == bps_pkg::OpLoad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_len_q <= '0;
      patch_len_q <= '0;
    end else if (cfg_valid_i) begin
      if (!cfg_index_i) src_len_q <= cfg_data_i[16:0];
      else patch_len_q <= cfg_data_i;
    end
  end

  wire [23:0] endp = patch_len_q >= bps_pkg::FooterLen ? patch_len_q - bps_pkg::FooterLen : '0;
  wire [PW-1:0] src_lim = ({1'b0, src_len_q} < 18'(Depth)) ? PW'(src_len_q) : Depth;

  // Number decoder for the current byte.
  logic [63:0] nacc;
  logic [6:0]  nsh;
  logic        ndone;
  always_comb begin
    nacc = acc_q;
    nsh = sh_q;
    ndone = data_i[7];
    // A continued number also gains the implicit one just above this group.
    if (sh_q < bps_pkg::ShiftStop) begin
      nacc = acc_q + ({56'd0, ~ndone, data_i[6:0]} << sh_q[5:0]);
      if (!ndone) nsh = sh_q + 7'd7;
    end
  end

  assign sraddr = (kind_q == bps_pkg::KindSrcRead) ? tpos_q[ADDR_BITS-1:0]
                                                   : srel_q[ADDR_BITS-1:0];
  assign traddr = trel_q[ADDR_BITS-1:0];

  bps_mem #(.AW(ADDR_BITS)) u_src (.clk_i, .we_i(swe), .waddr_i(address_i[ADDR_BITS-1:0]),
    .wdata_i(data_i), .raddr_i(sraddr), .rdata_o(sdata));
  bps_mem #(.AW(ADDR_BITS)) u_tgt (.clk_i, .we_i(twe), .waddr_i(twaddr),
    .wdata_i(twdata), .raddr_i(traddr), .rdata_o(tdata));

  always_comb begin
    logic        prod;
    logic [7:0]  pb;
    logic [63:0] v, mag;
    logic [PW:0] n, rel;
    logic        cerr;
    ph_d = ph_q; acc_d = acc_q; sh_d = sh_q; ppos_d = ppos_q; meta_d = meta_q;
    crem_d = crem_q; tpos_d = tpos_q; tsize_d = tsize_q; srel_d = srel_q;
    trel_d = trel_q; kind_d = kind_q;
    v_d = 1'b0; st_d = bps_pkg::StOk; b_d = '0; pos_d = '0; last_d = 1'b0;
    prod = 1'b0; pb = data_i; v = '0; mag = '0; n = '0; rel = '0; cerr = 1'b0;
    twe = 1'b0; twaddr = tpos_q[ADDR_BITS-1:0]; twdata = pb;
    if (rd_q) begin
      // Copy step, once the store read is done: checks and read data are ready.
      if (tpos_q >= tsize_q) cerr = 1'b1;
      else begin
        case (kind_q)
          bps_pkg::KindSrcRead: begin
            if (tpos_q >= src_lim) cerr = 1'b1;
            pb = sdata;
          end
          bps_pkg::KindSrcCopy: begin
            if (srel_q >= src_lim) cerr = 1'b1;
            else srel_d = srel_q + PW'(1);
            pb = sdata;
          end
          default: begin
            if (trel_q >= tpos_q) cerr = 1'b1;
            else trel_d = trel_q + PW'(1);
            pb = tdata;
          end
        endcase
      end
      if (cerr) begin
        ph_d = bps_pkg::PhError; v_d = 1'b1; st_d = bps_pkg::StRange;
      end else prod = 1'b1;
    end else if (acc_in && opcode_i == bps_pkg::OpPatch) begin
      if (ph_q == bps_pkg::PhCopy || ph_q == bps_pkg::PhError) begin
        v_d = 1'b1; st_d = bps_pkg::StRefused;
      end else if (ph_q != bps_pkg::PhDone) begin
        ppos_d = ppos_q + 24'd1;
        case (ph_q)
          bps_pkg::PhMagic0, bps_pkg::PhMagic1, bps_pkg::PhMagic2,
          bps_pkg::PhMagic3: begin
            if (data_i != bps_pkg::magic_byte(ph_q[1:0])) begin
              ph_d = bps_pkg::PhError; v_d = 1'b1; st_d = bps_pkg::StMagic;
            end else ph_d = bps_pkg::phase_e'(ph_q + 4'd1);
          end
          bps_pkg::PhSrcSize, bps_pkg::PhTgtSize, bps_pkg::PhMetaSize,
          bps_pkg::PhCommand, bps_pkg::PhOffset: begin
            acc_d = nacc; sh_d = nsh;
            if (ndone) begin
              acc_d = '0; sh_d = '0; v = nacc;
              case (ph_q)
                bps_pkg::PhSrcSize: begin
                  if (v != {47'd0, src_len_q}) begin
                    ph_d = bps_pkg::PhError; v_d = 1'b1; st_d = bps_pkg::StSize;
                  end else ph_d = bps_pkg::PhTgtSize;
                end
                bps_pkg::PhTgtSize: begin
                  if (v > 64'(Depth)) begin
                    ph_d = bps_pkg::PhError; v_d = 1'b1; st_d = bps_pkg::StRange;
                  end else begin
                    tsize_d = v[PW-1:0]; ph_d = bps_pkg::PhMetaSize;
                  end
                end
                bps_pkg::PhMetaSize: begin
                  meta_d = (v > 64'(bps_pkg::Max24)) ? bps_pkg::Max24 : v[23:0];
                  if (meta_d == '0)
                    ph_d = (ppos_d >= endp) ? bps_pkg::PhDone : bps_pkg::PhCommand;
                  else ph_d = bps_pkg::PhMetaSkip;
                end
                bps_pkg::PhCommand: begin
                  kind_d = v[1:0];
                  mag = v >> 2;
                  crem_d = (mag >= 64'(bps_pkg::Max24)) ? bps_pkg::Max24
                                                        : mag[23:0] + 24'd1;
                  case (v[1:0])
                    bps_pkg::KindTgtRead: ph_d = bps_pkg::PhTgtData;
                    bps_pkg::KindSrcRead: ph_d = bps_pkg::PhCopy;
                    default: ph_d = bps_pkg::PhOffset;
                  endcase
                end
                default: begin
                  mag = v >> 1;
                  rel = (kind_q == bps_pkg::KindSrcCopy) ? {1'b0, srel_q} : {1'b0, trel_q};
                  if (mag > 64'({Depth, 1'b0})) cerr = 1'b1;
                  else begin
                    n = v[0] ? rel - mag[PW:0] : rel + mag[PW:0];
                    if (v[0] && mag[PW:0] > rel) cerr = 1'b1;
                    else if (n > {1'b0, Depth}) cerr = 1'b1;
                  end
                  if (cerr) begin
                    ph_d = bps_pkg::PhError; v_d = 1'b1; st_d = bps_pkg::StRange;
                  end else begin
                    if (kind_q == bps_pkg::KindSrcCopy) srel_d = n[PW-1:0];
                    else trel_d = n[PW-1:0];
                    ph_d = bps_pkg::PhCopy;
                  end
                end
              endcase
            end
          end
          bps_pkg::PhMetaSkip: begin
            meta_d = meta_q - 24'd1;
            if (meta_d == '0)
              ph_d = (ppos_d >= endp) ? bps_pkg::PhDone : bps_pkg::PhCommand;
          end
          bps_pkg::PhTgtData: prod = 1'b1;
          default: begin
            ph_d = bps_pkg::PhError; v_d = 1'b1; st_d = bps_pkg::StRefused;
          end
        endcase
      end
    end
    if (prod) begin
      if (tpos_q >= tsize_q || tpos_q >= Depth) begin
        ph_d = bps_pkg::PhError; v_d = 1'b1; st_d = bps_pkg::StRange;
      end else begin
        twe = 1'b1; twdata = pb;
        tpos_d = tpos_q + PW'(1);
        if (crem_q != '0) crem_d = crem_q - 24'd1;
        else crem_d = crem_q;
        if (crem_d == '0)
          ph_d = (ppos_d >= endp) ? bps_pkg::PhDone : bps_pkg::PhCommand;
        v_d = 1'b1; b_d = pb; pos_d = 16'(tpos_q[ADDR_BITS-1:0]);
        last_d = ph_d == bps_pkg::PhDone;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= bps_pkg::PhMagic0; acc_q <= '0; sh_q <= '0; ppos_q <= '0; meta_q <= '0;
      crem_q <= '0; tpos_q <= '0; tsize_q <= '0; srel_q <= '0; trel_q <= '0;
      kind_q <= '0; rd_q <= 1'b0; valid_o <= 1'b0;
    end else begin
      ph_q <= ph_d; acc_q <= acc_d; sh_q <= sh_d; ppos_q <= ppos_d; meta_q <= meta_d;
      crem_q <= crem_d; tpos_q <= tpos_d; tsize_q <= tsize_d; srel_q <= srel_d;
      trel_q <= trel_d; kind_q <= kind_d; valid_o <= v_d;
      rd_q <= acc_in && opcode_i == bps_pkg::OpStep && ph_q == bps_pkg::PhCopy;
    end
  end

  always_ff @(posedge clk_i) begin
    status_o <= st_d; out_byte_o <= b_d; out_position_o <= pos_d; last_o <= last_d;
  end
endmodule
`default_nettype wire

@@ tb/bps_patch_apply_tb.sv @@
// Self-checking testbench for the BPS patch applier: loads a source, streams one
// well-formed patch with random segments and checks every result word.
// Depends on bps_pkg and bps_patch_apply.
`default_nettype none
module bps_patch_apply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic RegSourceLen = 1'b0;
  localparam logic RegPatchLen  = 1'b1;
  localparam logic [1:0] OpNone = 2'd3;
  localparam int SrcBytes = 128;
  localparam int CycleLimit = 2000000;
  localparam int RandomItems = 380;

  typedef struct {
    logic [2:0]  st;
    logic [7:0]  b;
    logic [15:0] pos;
    logic        lst;
  } patch_word_t;

  // Keeps its own copy of the applier state and the words it must produce.
  class patch_scoreboard;
    bit [7:0]    src_mem [65536];
    bit [7:0]    tgt_mem [65536];
    bit [7:0]    magic [4] = '{8'h42, 8'h50, 8'h53, 8'h31};
    bit [16:0]   src_len;
    bit [23:0]   patch_len;
    bps_pkg::phase_e phase;
    bit [63:0]   acc;
    int unsigned shift;
    bit [23:0]   ppos, meta_left, copy_left;
    int unsigned tpos, tgt_size;
    longint      src_rel, tgt_rel;
    bit [1:0]    kind;
    patch_word_t pending [$];
    int          errors;

    function new();
      phase = bps_pkg::PhMagic0;
    endfunction

    function void push(logic [2:0] st, logic [7:0] b, logic [15:0] pos, logic lst);
      patch_word_t w;
      w.st = st; w.b = b; w.pos = pos; w.lst = lst;
      pending.push_back(w);
    endfunction

    function void fail(logic [2:0] code);
      phase = bps_pkg::PhError;
      push(code, 8'd0, 16'd0, 1'b0);
    endfunction

    function void seg_boundary();
      bit [23:0] ep;
      ep = (patch_len >= bps_pkg::FooterLen) ? patch_len - bps_pkg::FooterLen : 24'd0;
      phase = (ppos >= ep) ? bps_pkg::PhDone : bps_pkg::PhCommand;
    endfunction

    function bit take_number(bit [7:0] b);
      if (shift < 64) acc += {57'd0, b[6:0]} << shift;
      if (b[7]) return 1'b1;
      if (shift < 64) shift += 7;
      if (shift < 64) acc += 64'd1 << shift;
      return 1'b0;
    endfunction

    function bit [63:0] fetch_number();
      bit [63:0] v;
      v = acc;
      acc = '0;
      shift = 0;
      return v;
    endfunction

    function void produce(bit [7:0] b);
      int unsigned pos;
      if (tpos >= tgt_size || tpos >= 65536) begin
        fail(bps_pkg::StRange);
        return;
      end
      pos = tpos;
      tgt_mem[pos[15:0]] = b;
      tpos++;
      if (copy_left > 0) copy_left--;
      if (copy_left == 0) seg_boundary();
      push(bps_pkg::StOk, b, pos[15:0], phase == bps_pkg::PhDone);
    endfunction

    function void patch_byte(bit [7:0] b);
      bit [63:0] v, mag;
      longint rel, n;
      if (phase == bps_pkg::PhCopy || phase == bps_pkg::PhError) begin
        push(bps_pkg::StRefused, 8'd0, 16'd0, 1'b0);
        return;
      end
      if (phase == bps_pkg::PhDone) return;
      ppos = ppos + 24'd1;
      if (phase < bps_pkg::PhSrcSize) begin
        if (b != magic[phase]) fail(bps_pkg::StMagic);
        else phase = bps_pkg::phase_e'(phase + 1);
        return;
      end
      case (phase)
        bps_pkg::PhSrcSize: if (take_number(b)) begin
          if (fetch_number() != {47'd0, src_len}) fail(bps_pkg::StSize);
          else phase = bps_pkg::PhTgtSize;
        end
        bps_pkg::PhTgtSize: if (take_number(b)) begin
          v = fetch_number();
          if (v > 64'd65536) fail(bps_pkg::StRange);
          else begin
            tgt_size = v[31:0];
            phase = bps_pkg::PhMetaSize;
          end
        end
        bps_pkg::PhMetaSize: if (take_number(b)) begin
          v = fetch_number();
          meta_left = (v > bps_pkg::Max24) ? bps_pkg::Max24 : v[23:0];
          if (meta_left == 0) seg_boundary();
          else phase = bps_pkg::PhMetaSkip;
        end
        bps_pkg::PhMetaSkip: begin
          meta_left--;
          if (meta_left == 0) seg_boundary();
        end
        bps_pkg::PhCommand: if (take_number(b)) begin
          v = fetch_number();
          kind = v[1:0];
          v = v >> 2;
          copy_left = (v >= bps_pkg::Max24) ? bps_pkg::Max24 : v[23:0] + 24'd1;
          if (kind == bps_pkg::KindTgtRead) phase = bps_pkg::PhTgtData;
          else if (kind == bps_pkg::KindSrcRead) phase = bps_pkg::PhCopy;
          else phase = bps_pkg::PhOffset;
        end
        bps_pkg::PhTgtData: produce(b);
        bps_pkg::PhOffset: if (take_number(b)) begin
          v = fetch_number();
          mag = v >> 1;
          if (mag > 64'd131072) begin
            fail(bps_pkg::StRange);
            return;
          end
          rel = (kind == bps_pkg::KindSrcCopy) ? src_rel : tgt_rel;
          n = v[0] ? rel - longint'(mag) : rel + longint'(mag);
          if (n < 0 || n > 65536) begin
            fail(bps_pkg::StRange);
            return;
          end
          if (kind == bps_pkg::KindSrcCopy) src_rel = n;
          else tgt_rel = n;
          phase = bps_pkg::PhCopy;
        end
        default: fail(bps_pkg::StRefused);
      endcase
    endfunction

    function void copy_step();
      int unsigned lim;
      bit [7:0] b;
      if (phase != bps_pkg::PhCopy) return;
      lim = (src_len < 65536) ? src_len : 65536;
      if (tpos >= tgt_size) begin
        fail(bps_pkg::StRange);
        return;
      end
      if (kind == bps_pkg::KindSrcRead) begin
        if (tpos >= lim) begin
          fail(bps_pkg::StRange);
          return;
        end
        b = src_mem[tpos[15:0]];
      end else if (kind == bps_pkg::KindSrcCopy) begin
        if (src_rel < 0 || src_rel >= lim) begin
          fail(bps_pkg::StRange);
          return;
        end
        b = src_mem[src_rel[15:0]];
        src_rel++;
      end else begin
        if (tgt_rel < 0 || tgt_rel >= tpos) begin
          fail(bps_pkg::StRange);
          return;
        end
        b = tgt_mem[tgt_rel[15:0]];
        tgt_rel++;
      end
      produce(b);
    endfunction

    function void note_input(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
      case (op)
        bps_pkg::OpLoad:  src_mem[addr] = data;
        bps_pkg::OpPatch: patch_byte(data);
        bps_pkg::OpStep:  copy_step();
        default: ;
      endcase
    endfunction

    function void write_reg(logic idx, logic [23:0] val);
      if (idx == RegSourceLen) src_len = val[16:0];
      else patch_len = val;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [2:0] st, logic [7:0] b, logic [15:0] pos, logic lst);
      patch_word_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word status %0d byte %h pos %0d", st, b, pos));
        return;
      end
      e = pending.pop_front();
      if (st !== e.st || b !== e.b || pos !== e.pos || lst !== e.lst)
        report($sformatf("got st %0d byte %h pos %0d last %b, want %0d %h %0d %b",
                         st, b, pos, lst, e.st, e.b, e.pos, e.lst));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = OpNone;
  logic [15:0] address_i = '0;
  logic [7:0]  data_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [23:0] cfg_data_i = '0;
  logic        valid_o;
  logic [2:0]  status_o;
  logic [7:0]  out_byte_o;
  logic [15:0] out_position_o;
  logic        last_o;

  patch_scoreboard sb = new();
  int idle_pct = 0;
  int cycles = 0;
  int sent = 0;

  bps_patch_apply dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(status_o, out_byte_o, out_position_o, last_o);
  end

  // Offers one word and waits until the block takes it.
  task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    address_i <= addr;
    data_i <= data;
    do @(posedge clk_i); while (busy);
    sb.note_input(op, addr, data);
  endtask

  // Lets the block drain before a register write.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_patch(logic [7:0] b);
    send_item(bps_pkg::OpPatch, 16'($urandom), b);
    sent++;
  endtask

  // BPS number coding: seven bits per byte, the top bit marks the last byte.
  task automatic send_number(longint unsigned v);
    logic [7:0] x;
    forever begin
      x = {1'b0, v[6:0]};
      v = v >> 7;
      if (v == 0) begin
        send_patch(x | 8'h80);
        break;
      end
      send_patch(x);
      v = v - 1;
    end
  endtask

  // Occasional harmless words between segments: ignored opcode, idle step or a load.
  task automatic noise();
    case ($urandom_range(2))
      0: send_item(OpNone, 16'($urandom), 8'($urandom));
      1: send_item(bps_pkg::OpStep, 16'($urandom), 8'($urandom));
      default: send_item(bps_pkg::OpLoad, 16'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic do_segment(logic [1:0] k, int len, longint new_rel);
    longint d;
    send_number(((len - 1) << 2) | k);
    if (k == bps_pkg::KindTgtRead) begin
      for (int i = 0; i < len; i++) send_patch(8'($urandom));
      return;
    end
    if (k != bps_pkg::KindSrcRead) begin
      d = new_rel - ((k == bps_pkg::KindSrcCopy) ? sb.src_rel : sb.tgt_rel);
      send_number(d < 0 ? ((-d) << 1) | 1 : d << 1);
    end
    for (int i = 0; i < len; i++) begin
      // A patch byte while a copy is pending must be refused.
      if ($urandom_range(9) == 0) send_item(bps_pkg::OpPatch, 16'($urandom), 8'($urandom));
      send_item(bps_pkg::OpStep, 16'($urandom), 8'($urandom));
      sent++;
    end
  endtask

  task automatic random_segment();
    int len;
    int k;
    len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
    k = $urandom_range(3);
    if (k == bps_pkg::KindSrcRead && sb.tpos + len > SrcBytes) k = bps_pkg::KindTgtRead;
    if (k == bps_pkg::KindTgtCopy && sb.tpos == 0) k = bps_pkg::KindTgtRead;
    case (k)
      bps_pkg::KindSrcCopy:
        do_segment(bps_pkg::KindSrcCopy, len, $urandom_range(0, SrcBytes - len));
      bps_pkg::KindTgtCopy:
        do_segment(bps_pkg::KindTgtCopy, len, $urandom_range(0, sb.tpos - 1));
      default: do_segment(k[1:0], len, 0);
    endcase
    if ($urandom_range(5) == 0) noise();
  endtask

  initial begin
    int pcts [4] = '{0, 74, 0, 16};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(RegSourceLen, 24'(SrcBytes));
    write_reg(RegPatchLen, bps_pkg::Max24);
    for (int a = 0; a < SrcBytes; a++) send_item(bps_pkg::OpLoad, a[15:0], 8'($urandom));

    // Header: magic, sizes (largest target), three metadata bytes.
    foreach (sb.magic[i]) send_patch(sb.magic[i]);
    send_number(SrcBytes);
    send_number(65536);
    send_number(3);
    repeat (3) send_patch(8'($urandom));
    send_item(bps_pkg::OpStep, '0, '0);
    send_number((3 << 2) | bps_pkg::KindTgtRead);
    send_patch(8'h00);
    send_patch(8'hFF);
    send_patch(8'h55);
    send_patch(8'hAA);
    do_segment(bps_pkg::KindSrcRead, 2, 0);
    do_segment(bps_pkg::KindSrcCopy, 1, SrcBytes - 1);
    do_segment(bps_pkg::KindSrcCopy, 1, 0);
    do_segment(bps_pkg::KindTgtCopy, 3, 0);
    send_item(OpNone, 16'hFFFF, 8'hFF);

    for (int ph = 0; sent < RandomItems + 60; ph++) begin
      idle_pct = pcts[ph % 4];
      for (int n = 0; n < 10; n++) random_segment();
    end
    idle_pct = 0;

    // Move the end point to here: the next segment finishes the patch.
    settle();
    write_reg(RegPatchLen, sb.ppos + bps_pkg::FooterLen);
    do_segment(bps_pkg::KindTgtRead, 3, 0);
    repeat (4) send_patch(8'($urandom));
    send_item(bps_pkg::OpStep, '0, '0);
    settle();
    write_reg(RegPatchLen, 24'd0);
    write_reg(RegSourceLen, 24'd0);
    write_reg(RegSourceLen, 24'd65536);
    send_patch(8'h42);
    send_item(bps_pkg::OpStep, '0, '0);
    settle();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
